// ===== design/scatter_density_gradient_update_defines.svh =====
// assertion macros for the scatter density gradient update block
`ifndef SCATTER_DENSITY_GRADIENT_UPDATE_DEFINES_SVH
`define SCATTER_DENSITY_GRADIENT_UPDATE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SDGU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SDGU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sdgu_pkg.sv =====
// types, sizes and codes of the scatter density gradient update block
package sdgu_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_MUONS   = 1024;
    localparam int NUM_VOXELS  = 4096;

    localparam int ENT_AW    = $clog2(MAX_ENTRIES);
    localparam int MU_AW     = $clog2(MAX_MUONS);
    localparam int VX_AW     = $clog2(NUM_VOXELS);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int SWEEP_MAX = (MAX_ENTRIES > NUM_VOXELS) ? MAX_ENTRIES : NUM_VOXELS;
    localparam int IDX_W     = $clog2(SWEEP_MAX + 1);

    localparam int OP_W   = 3;
    localparam int MUON_W = 10;
    localparam int VOX_W  = 12;
    localparam int LEN_W  = 20;
    localparam int SCAT_W = 32;
    localparam int DENS_W = 40;
    localparam int STAT_W = 2;
    localparam int HELD_W = 13;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // |sigma - scatter*2^16| is 48 bits, quotient numerator is shifted by 48
    localparam int DIFF_W    = 48;
    localparam int NUM_W     = LEN_W + DIFF_W + 48;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [DENS_W-1:0] DENSITY_FLOOR_RST    = 40'd9262092027;
    localparam logic [DENS_W-1:0] SIGMA_OFFSET_RST     = 40'd13792273859;
    localparam logic [31:0]       ENERGY_PREFACTOR_RST = 32'd794397;
    localparam logic [31:0]       STEP_SIZE_RST        = 32'd0;

    localparam logic [OP_W-1:0] OP_LOAD_ENTRY   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SCATTER = 3'd1;
    localparam logic [OP_W-1:0] OP_RUN_STEP     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_DENSITY = 3'd3;
    localparam logic [OP_W-1:0] OP_INIT_DENSITY = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREFACTOR   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [MUON_W-1:0] muon_index;
        logic [VOX_W-1:0]  voxel_index;
        logic [LEN_W-1:0]  path_length;
        logic [SCAT_W-1:0] scatter_sq;
    } item_t;

    typedef struct packed {
        logic [DENS_W-1:0] density_value;
        logic [STAT_W-1:0] status;
        logic [HELD_W-1:0] entries_held;
    } result_t;

endpackage

// ===== design/scatter_density_gradient_update.sv =====
// top level: sequenced descent engine around one shared 32x32 multiplier
// run: clear sweep, sum per entry, sigma per muon, gradient per entry (skipped if sigma is zero), update per voxel
// run time is set by the 116-step restoring divider and the single multiplier
// item_ready is low for the whole of a run or init, while a read fetches its data, and while a result waits
// reset: async active low, then a sweep over every voxel fills densities and clears scatter
`include "scatter_density_gradient_update_defines.svh"

module scatter_density_gradient_update (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  sdgu_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output sdgu_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdgu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdgu_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sdgu_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_WIPE = 5'd1;   // density fill / scatter clear sweep
    localparam logic [4:0] S_RDV  = 5'd2;   // density read data back
    localparam logic [4:0] S_CLR  = 5'd3;   // clear gradients and muon sums
    localparam logic [4:0] S_A_ENT = 5'd4;  // sum phase
    localparam logic [4:0] S_A_RD  = 5'd5;
    localparam logic [4:0] S_A_M0  = 5'd6;
    localparam logic [4:0] S_A_M1  = 5'd7;
    localparam logic [4:0] S_A_AC  = 5'd8;
    localparam logic [4:0] S_B_RD  = 5'd9;  // sigma phase
    localparam logic [4:0] S_B_M0  = 5'd10;
    localparam logic [4:0] S_B_M1  = 5'd11;
    localparam logic [4:0] S_B_WR  = 5'd12;
    localparam logic [4:0] S_C_ENT = 5'd13; // gradient phase
    localparam logic [4:0] S_C_RD  = 5'd14;
    localparam logic [4:0] S_C_DF  = 5'd15;
    localparam logic [4:0] S_C_Q1  = 5'd16;
    localparam logic [4:0] S_C_Q2  = 5'd17;
    localparam logic [4:0] S_C_Q3  = 5'd18;
    localparam logic [4:0] S_C_N1  = 5'd19;
    localparam logic [4:0] S_C_N2  = 5'd20;
    localparam logic [4:0] S_C_DIV = 5'd21;
    localparam logic [4:0] S_C_GR  = 5'd22;
    localparam logic [4:0] S_C_GW  = 5'd23;
    localparam logic [4:0] S_D_RD  = 5'd24; // density update phase
    localparam logic [4:0] S_D_M0  = 5'd25;
    localparam logic [4:0] S_D_M1  = 5'd26;
    localparam logic [4:0] S_D_WR  = 5'd27;

    localparam int ENT_W = MUON_W + VOX_W + LEN_W;
    localparam logic [DENS_W-1:0] MASK40 = '1;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

    // control registers
    logic [4:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              wipe_init_reg, wipe_init_next;
    logic              result_valid_reg, result_valid_next;
    logic [31:0]       step_reg, pref_reg;
    logic [DENS_W-1:0] floor_reg, offset_reg;

    // datapath registers
    logic [MU_AW-1:0]  e_muon_reg, e_muon_next;
    logic [VX_AW-1:0]  e_voxel_reg, e_voxel_next;
    logic [LEN_W-1:0]  e_len_reg, e_len_next;
    logic [63:0]       op_reg, op_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       tmp_reg, tmp_next;
    logic [63:0]       mul_reg;
    logic              neg_reg, neg_next;
    logic              pos_reg, pos_next;
    logic [79:0]       den_reg, den_next;
    logic [79:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [62:0]       quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    result_t           result_reg, result_next;
    logic              res_load;

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;

    // memories and their ports
    logic [ENT_W-1:0]  ent_mem [MAX_ENTRIES];
    logic [SCAT_W-1:0] scat_mem [MAX_MUONS];
    logic [DENS_W-1:0] dens_mem [NUM_VOXELS];
    logic [DENS_W-1:0] sig_mem [MAX_MUONS];
    logic [63:0]       sum_mem [MAX_MUONS];
    logic [63:0]       grad_mem [NUM_VOXELS];

    logic              ent_we, scat_we, dens_we, sig_we, sum_we, grad_we;
    logic [ENT_AW-1:0] ent_wa, ent_ra;
    logic [MU_AW-1:0]  scat_wa, scat_ra, sig_wa, sig_ra, sum_wa, sum_ra;
    logic [VX_AW-1:0]  dens_wa, dens_ra, grad_wa, grad_ra;
    logic [ENT_W-1:0]  ent_wd, ent_rd;
    logic [SCAT_W-1:0] scat_wd, scat_rd;
    logic [DENS_W-1:0] dens_wd, dens_rd, sig_wd, sig_rd;
    logic [63:0]       sum_wd, sum_rd, grad_wd, grad_rd;

    // combinational helpers
    logic              accept;
    logic              muon_oor, voxel_oor;
    logic [IDX_W-1:0]  idx_inc;
    logic              ent_last;
    logic [MU_AW-1:0]  rd_muon;
    logic [VX_AW-1:0]  rd_voxel;
    logic [LEN_W-1:0]  rd_len;
    logic [63:0]       a_prod, a_part;
    logic [64:0]       a_sum;
    logic [63:0]       b_sig;
    logic [DENS_W-1:0] b_lim;
    logic [48:0]       c_diff;
    logic [DIFF_W-1:0] c_adiff;
    logic [67:0]       c_num;
    logic [80:0]       c_rsh;
    logic              c_fit;
    logic [63:0]       c_mag, c_term;
    logic [64:0]       c_gsum;
    logic [63:0]       d_ag;
    logic [95:0]       d_delta;
    logic [DENS_W-1:0] d_den, d_new;

    assign item_ready   = (state_reg == S_IDLE) && (!result_valid_reg || result_ready);
    assign accept       = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign muon_oor  = 32'(item.muon_index) >= MAX_MUONS;
    assign voxel_oor = 32'(item.voxel_index) >= NUM_VOXELS;
    assign idx_inc   = idx_reg + 1'b1;
    assign ent_last  = idx_inc == IDX_W'(count_reg);

    assign rd_muon  = ent_rd[ENT_W-1 -: MU_AW];
    assign rd_voxel = ent_rd[LEN_W +: VX_AW];
    assign rd_len   = ent_rd[LEN_W-1:0];

    // sum phase: length times density, 48 fraction bits, saturating sum
    assign a_prod = (mul_reg << 32) + tmp_reg;
    assign a_part = a_prod >> 8;
    assign a_sum  = {1'b0, acc_reg} + {1'b0, a_part};

    // sigma phase: bits 95:32 of prefactor times sum
    assign b_sig = mul_reg + (tmp_reg >> 32);
    assign b_lim = MASK40 - offset_reg;

    // gradient phase
    assign c_diff  = {9'b0, sig_rd} - {1'b0, scat_rd, 16'b0};
    assign c_adiff = c_diff[48] ? DIFF_W'(49'd0 - c_diff) : c_diff[DIFF_W-1:0];
    assign c_num   = (68'(mul_reg) << 32) + 68'(tmp_reg);
    assign c_rsh   = {rem_reg, num_reg[NUM_W-1]};
    assign c_fit   = c_rsh >= {1'b0, den_reg};
    assign c_mag   = ovf_reg ? INT64_MAX : {1'b0, quo_reg};
    assign c_term  = neg_reg ? (64'd0 - c_mag) : c_mag;
    assign c_gsum  = {grad_rd[63], grad_rd} + {c_term[63], c_term};

    // update phase
    assign d_ag    = grad_rd[63] ? (64'd0 - grad_rd) : grad_rd;
    assign d_delta = (96'(mul_reg) << 32) + 96'(tmp_reg);
    assign d_den   = op_reg[DENS_W-1:0];

    always_comb
    begin
        if (pos_reg)
        begin
            d_new = (d_delta > 96'(d_den)) ? '0 : d_den - DENS_W'(d_delta);
        end
        else
        begin
            d_new = (d_delta > 96'(MASK40 - d_den)) ? MASK40 : d_den + DENS_W'(d_delta);
        end
        if (d_new < floor_reg)
        begin
            d_new = floor_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        wipe_init_next    = wipe_init_reg;
        e_muon_next       = e_muon_reg;
        e_voxel_next      = e_voxel_reg;
        e_len_next        = e_len_reg;
        op_next           = op_reg;
        acc_next          = acc_reg;
        tmp_next          = tmp_reg;
        neg_next          = neg_reg;
        pos_next          = pos_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        num_next          = num_reg;
        quo_next          = quo_reg;
        ovf_next          = ovf_reg;
        dcnt_next         = dcnt_reg;
        mul_a             = '0;
        mul_b             = '0;
        res_load          = 1'b0;
        result_next       = result_reg;

        ent_we  = 1'b0; ent_wa  = '0; ent_wd  = '0; ent_ra  = idx_reg[ENT_AW-1:0];
        scat_we = 1'b0; scat_wa = '0; scat_wd = '0; scat_ra = rd_muon;
        dens_we = 1'b0; dens_wa = '0; dens_wd = '0; dens_ra = idx_reg[VX_AW-1:0];
        sig_we  = 1'b0; sig_wa  = '0; sig_wd  = '0; sig_ra  = rd_muon;
        sum_we  = 1'b0; sum_wa  = '0; sum_wd  = '0; sum_ra  = idx_reg[MU_AW-1:0];
        grad_we = 1'b0; grad_wa = '0; grad_wd = '0; grad_ra = idx_reg[VX_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                dens_ra = item.voxel_index[VX_AW-1:0];
                if (accept)
                begin
                    result_next.density_value = '0;
                    result_next.status        = ST_OK;
                    case (item.operation)
                        OP_LOAD_ENTRY:
                        begin
                            res_load = 1'b1;
                            if (muon_oor || voxel_oor)
                            begin
                                result_next.status = ST_RANGE;
                            end
                            else if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                ent_wa     = count_reg[ENT_AW-1:0];
                                ent_wd     = {item.muon_index[MU_AW-1:0],
                                              item.voxel_index[VX_AW-1:0], item.path_length};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_LOAD_SCATTER:
                        begin
                            res_load = 1'b1;
                            if (muon_oor)
                            begin
                                result_next.status = ST_RANGE;
                            end
                            else
                            begin
                                scat_we = 1'b1;
                                scat_wa = item.muon_index[MU_AW-1:0];
                                scat_wd = item.scatter_sq;
                            end
                        end
                        OP_RUN_STEP:
                        begin
                            idx_next   = '0;
                            state_next = S_CLR;
                        end
                        OP_READ_DENSITY:
                        begin
                            if (voxel_oor)
                            begin
                                res_load           = 1'b1;
                                result_next.status = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_RDV;
                            end
                        end
                        OP_INIT_DENSITY:
                        begin
                            idx_next       = '0;
                            wipe_init_next = 1'b1;
                            state_next     = S_WIPE;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_RDV:
            begin
                res_load                  = 1'b1;
                result_next.density_value = dens_rd;
                result_next.status        = ST_OK;
                state_next                = S_IDLE;
            end
            S_WIPE:
            begin
                dens_we = 1'b1;
                dens_wa = idx_reg[VX_AW-1:0];
                dens_wd = wipe_init_reg ? floor_reg : DENSITY_FLOOR_RST;
                if (!wipe_init_reg && (32'(idx_reg) < MAX_MUONS))
                begin
                    scat_we = 1'b1;
                    scat_wa = idx_reg[MU_AW-1:0];
                    scat_wd = '0;
                end
                if (idx_reg == IDX_W'(NUM_VOXELS - 1))
                begin
                    if (wipe_init_reg)
                    begin
                        res_load                  = 1'b1;
                        result_next.density_value = '0;
                        result_next.status        = ST_OK;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_CLR:
            begin
                grad_we = 1'b1;
                grad_wa = idx_reg[VX_AW-1:0];
                if (32'(idx_reg) < MAX_MUONS)
                begin
                    sum_we = 1'b1;
                    sum_wa = idx_reg[MU_AW-1:0];
                end
                if (idx_reg == IDX_W'(NUM_VOXELS - 1))
                begin
                    idx_next   = '0;
                    state_next = (count_reg == '0) ? S_B_RD : S_A_ENT;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_A_ENT:
            begin
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                e_muon_next  = rd_muon;
                e_voxel_next = rd_voxel;
                e_len_next   = rd_len;
                dens_ra      = rd_voxel;
                sum_ra       = rd_muon;
                state_next   = S_A_M0;
            end
            S_A_M0:
            begin
                op_next    = 64'(dens_rd);
                acc_next   = sum_rd;
                mul_a      = 32'(e_len_reg);
                mul_b      = dens_rd[31:0];
                state_next = S_A_M1;
            end
            S_A_M1:
            begin
                tmp_next   = mul_reg;
                mul_a      = 32'(e_len_reg);
                mul_b      = 32'(op_reg[DENS_W-1:32]);
                state_next = S_A_AC;
            end
            S_A_AC:
            begin
                sum_we = 1'b1;
                sum_wa = e_muon_reg;
                sum_wd = a_sum[64] ? '1 : a_sum[63:0];
                if (ent_last)
                begin
                    idx_next   = '0;
                    state_next = S_B_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_A_ENT;
                end
            end
            S_B_RD:
            begin
                state_next = S_B_M0;
            end
            S_B_M0:
            begin
                acc_next   = sum_rd;
                mul_a      = pref_reg;
                mul_b      = sum_rd[31:0];
                state_next = S_B_M1;
            end
            S_B_M1:
            begin
                tmp_next   = mul_reg;
                mul_a      = pref_reg;
                mul_b      = acc_reg[63:32];
                state_next = S_B_WR;
            end
            S_B_WR:
            begin
                sig_we = 1'b1;
                sig_wa = idx_reg[MU_AW-1:0];
                sig_wd = (b_sig > 64'(b_lim)) ? MASK40 : DENS_W'(b_sig) + offset_reg;
                if (idx_reg == IDX_W'(MAX_MUONS - 1))
                begin
                    idx_next   = '0;
                    state_next = (count_reg == '0) ? S_D_RD : S_C_ENT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_B_RD;
                end
            end
            S_C_ENT:
            begin
                state_next = S_C_RD;
            end
            S_C_RD:
            begin
                e_muon_next  = rd_muon;
                e_voxel_next = rd_voxel;
                e_len_next   = rd_len;
                state_next   = S_C_DF;
            end
            S_C_DF:
            begin
                if (sig_rd == '0)
                begin
                    // zero sigma adds nothing
                    if (ent_last)
                    begin
                        idx_next   = '0;
                        state_next = S_D_RD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_C_ENT;
                    end
                end
                else
                begin
                    op_next    = 64'(sig_rd);
                    acc_next   = 64'(c_adiff);
                    neg_next   = c_diff[48];
                    mul_a      = sig_rd[31:0];
                    mul_b      = sig_rd[31:0];
                    state_next = S_C_Q1;
                end
            end
            S_C_Q1:
            begin
                den_next   = 80'(mul_reg);
                mul_a      = op_reg[31:0];
                mul_b      = 32'(op_reg[DENS_W-1:32]);
                state_next = S_C_Q2;
            end
            S_C_Q2:
            begin
                den_next   = den_reg + (80'(mul_reg) << 33);
                mul_a      = 32'(op_reg[DENS_W-1:32]);
                mul_b      = 32'(op_reg[DENS_W-1:32]);
                state_next = S_C_Q3;
            end
            S_C_Q3:
            begin
                den_next   = den_reg + (80'(mul_reg) << 64);
                mul_a      = 32'(e_len_reg);
                mul_b      = acc_reg[31:0];
                state_next = S_C_N1;
            end
            S_C_N1:
            begin
                tmp_next   = mul_reg;
                mul_a      = 32'(e_len_reg);
                mul_b      = 32'(acc_reg[DIFF_W-1:32]);
                state_next = S_C_N2;
            end
            S_C_N2:
            begin
                num_next   = {c_num, 48'b0};
                rem_next   = '0;
                quo_next   = '0;
                ovf_next   = 1'b0;
                dcnt_next  = '0;
                state_next = S_C_DIV;
            end
            S_C_DIV:
            begin
                // one restoring division step per cycle
                rem_next  = c_fit ? 80'(c_rsh - {1'b0, den_reg}) : c_rsh[79:0];
                num_next  = num_reg << 1;
                quo_next  = {quo_reg[61:0], c_fit};
                ovf_next  = ovf_reg | quo_reg[62];
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_C_GR;
                end
            end
            S_C_GR:
            begin
                grad_ra    = e_voxel_reg;
                state_next = S_C_GW;
            end
            S_C_GW:
            begin
                grad_we = 1'b1;
                grad_wa = e_voxel_reg;
                if (c_gsum[64] != c_gsum[63])
                begin
                    grad_wd = c_gsum[64] ? INT64_MIN : INT64_MAX;
                end
                else
                begin
                    grad_wd = c_gsum[63:0];
                end
                if (ent_last)
                begin
                    idx_next   = '0;
                    state_next = S_D_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_C_ENT;
                end
            end
            S_D_RD:
            begin
                state_next = S_D_M0;
            end
            S_D_M0:
            begin
                op_next    = 64'(dens_rd);
                acc_next   = d_ag;
                pos_next   = !grad_rd[63] && (grad_rd != '0);
                mul_a      = step_reg;
                mul_b      = d_ag[31:0];
                state_next = S_D_M1;
            end
            S_D_M1:
            begin
                tmp_next   = mul_reg;
                mul_a      = step_reg;
                mul_b      = acc_reg[63:32];
                state_next = S_D_WR;
            end
            S_D_WR:
            begin
                dens_we = 1'b1;
                dens_wa = idx_reg[VX_AW-1:0];
                dens_wd = d_new;
                if (idx_reg == IDX_W'(NUM_VOXELS - 1))
                begin
                    res_load                  = 1'b1;
                    result_next.density_value = '0;
                    result_next.status        = ST_OK;
                    state_next                = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_D_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            result_next.entries_held = HELD_W'(count_next);
        end
        result_valid_next = res_load || (result_valid_reg && !result_ready);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_WIPE;
            idx_reg          <= '0;
            count_reg        <= '0;
            wipe_init_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            step_reg         <= STEP_SIZE_RST;
            floor_reg        <= DENSITY_FLOOR_RST;
            offset_reg       <= SIGMA_OFFSET_RST;
            pref_reg         <= ENERGY_PREFACTOR_RST;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            wipe_init_reg    <= wipe_init_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_STEP_SIZE: step_reg   <= cfg_data[31:0];
                    REG_FLOOR:     floor_reg  <= cfg_data;
                    REG_OFFSET:    offset_reg <= cfg_data;
                    REG_PREFACTOR: pref_reg   <= cfg_data[31:0];
                    default:       step_reg   <= step_reg;
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        e_muon_reg  <= e_muon_next;
        e_voxel_reg <= e_voxel_next;
        e_len_reg   <= e_len_next;
        op_reg      <= op_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        mul_reg     <= mul_a * mul_b;
        neg_reg     <= neg_next;
        pos_reg     <= pos_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        ovf_reg     <= ovf_next;
        dcnt_reg    <= dcnt_next;
        result_reg  <= result_next;
    end

    // memories, registered reads
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        ent_rd <= ent_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (scat_we)
        begin
            scat_mem[scat_wa] <= scat_wd;
        end
        scat_rd <= scat_mem[scat_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dens_we)
        begin
            dens_mem[dens_wa] <= dens_wd;
        end
        dens_rd <= dens_mem[dens_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sig_we)
        begin
            sig_mem[sig_wa] <= sig_wd;
        end
        sig_rd <= sig_mem[sig_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        sum_rd <= sum_mem[sum_ra];
    end

    always_ff @(posedge clk)
    begin
        if (grad_we)
        begin
            grad_mem[grad_wa] <= grad_wd;
        end
        grad_rd <= grad_mem[grad_ra];
    end

    // checks
    `SDGU_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES), "entry count overflow")
    `SDGU_ASSERT_NOW(a_div_rem, state_reg == S_C_DIV, rem_reg < den_reg, "divider remainder too big")
    `SDGU_ASSERT_NOW(a_out_free, (state_reg == S_D_WR) || (state_reg == S_RDV), !result_valid_reg, "result slot busy at completion")
    `SDGU_ASSERT_NEXT(a_run_start, accept && (item.operation == OP_RUN_STEP), state_reg == S_CLR, "run did not start")

endmodule

// ===== dv/scatter_density_gradient_update_tb.sv =====
// testbench for the scatter density gradient update block: scoreboard, drivers and checks
`timescale 1ns / 100ps

module scatter_density_gradient_update_tb;
    import sdgu_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam logic [39:0] MASK40 = 40'hFF_FFFF_FFFF;

    // mirrors the block's state and works out one result per accepted transaction
    class density_scoreboard;
        logic [31:0] step_size;
        logic [39:0] floor_level;
        logic [39:0] sigma_offset;
        logic [31:0] prefactor;
        logic [MUON_W-1:0] ent_muon [MAX_ENTRIES];
        logic [VOX_W-1:0]  ent_voxel [MAX_ENTRIES];
        logic [LEN_W-1:0]  ent_len [MAX_ENTRIES];
        int unsigned       entry_count;
        logic [31:0]       scatter [MAX_MUONS];
        logic [39:0]       density [NUM_VOXELS];
        result_t           expected_results [$];
        int                errors;

        function new();
            step_size    = STEP_SIZE_RST;
            floor_level  = DENSITY_FLOOR_RST;
            sigma_offset = SIGMA_OFFSET_RST;
            prefactor    = ENERGY_PREFACTOR_RST;
            entry_count  = 0;
            errors       = 0;
            foreach (scatter[i]) scatter[i] = '0;
            foreach (density[i]) density[i] = DENSITY_FLOOR_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEP_SIZE: step_size    = data[31:0];
                REG_FLOOR:     floor_level  = data;
                REG_OFFSET:    sigma_offset = data;
                REG_PREFACTOR: prefactor    = data[31:0];
                default: ;
            endcase
        endfunction

        // one descent step over every loaded entry
        function void descend();
            logic [63:0]  muon_sum [MAX_MUONS];
            logic [39:0]  sigma [MAX_MUONS];
            longint       grad [NUM_VOXELS];
            logic [63:0]  prod, s64, adiff, mag, ag, r;
            logic [64:0]  wsum;
            logic [127:0] pr, num, den, q, delta;
            logic signed [64:0] gsum;
            longint       diff, term, g;
            int           m, v;
            foreach (muon_sum[i]) muon_sum[i] = '0;
            foreach (grad[i]) grad[i] = 0;
            // per-muon sum of length times density, saturating
            for (int i = 0; i < entry_count; i++)
            begin
                m    = ent_muon[i];
                prod = (64'(ent_len[i]) * 64'(density[ent_voxel[i]])) >> 8;
                wsum = {1'b0, muon_sum[m]} + {1'b0, prod};
                muon_sum[m] = wsum[64] ? '1 : wsum[63:0];
            end
            for (int i = 0; i < MAX_MUONS; i++)
            begin
                pr  = 128'(prefactor) * 128'(muon_sum[i]);
                s64 = pr[95:32];
                if (s64 > 64'(MASK40) - 64'(sigma_offset))
                    sigma[i] = MASK40;
                else
                    sigma[i] = 40'(s64 + 64'(sigma_offset));
            end
            // gradient terms, zero sigma adds nothing
            for (int i = 0; i < entry_count; i++)
            begin
                m = ent_muon[i];
                v = ent_voxel[i];
                if (sigma[m] == '0)
                    continue;
                diff  = longint'(64'(sigma[m])) - longint'(64'(scatter[m]) << 16);
                adiff = (diff < 0) ? 64'(-diff) : 64'(diff);
                num   = (128'(ent_len[i]) * 128'(adiff)) << 48;
                den   = 128'(sigma[m]) * 128'(sigma[m]);
                q     = num / den;
                mag   = (q > 128'(64'h7FFF_FFFF_FFFF_FFFF)) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
                term  = (diff < 0) ? -longint'(mag) : longint'(mag);
                gsum  = 65'(signed'(grad[v])) + 65'(signed'(term));
                if (gsum > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                    grad[v] = 64'h7FFF_FFFF_FFFF_FFFF;
                else if (gsum < -65'sh0_8000_0000_0000_0000)
                    grad[v] = 64'h8000_0000_0000_0000;
                else
                    grad[v] = gsum[63:0];
            end
            // every voxel updated and floored
            for (int i = 0; i < NUM_VOXELS; i++)
            begin
                g     = grad[i];
                ag    = (g < 0) ? 64'(-g) : 64'(g);
                delta = 128'(step_size) * 128'(ag);
                if (g > 0)
                    r = (delta > 128'(density[i])) ? 64'd0 : 64'(density[i]) - delta[63:0];
                else
                    r = (delta > 128'(MASK40 - density[i])) ? 64'(MASK40)
                                                             : 64'(density[i]) + delta[63:0];
                if (r < 64'(floor_level))
                    r = 64'(floor_level);
                density[i] = r[39:0];
            end
        endfunction

        function void note_item(item_t it);
            result_t res;
            res = '0;
            case (it.operation)
                OP_LOAD_ENTRY:
                begin
                    if (it.muon_index >= MAX_MUONS || it.voxel_index >= NUM_VOXELS)
                        res.status = ST_RANGE;
                    else if (entry_count >= MAX_ENTRIES)
                        res.status = ST_FULL;
                    else
                    begin
                        ent_muon[entry_count]  = it.muon_index;
                        ent_voxel[entry_count] = it.voxel_index;
                        ent_len[entry_count]   = it.path_length;
                        entry_count++;
                    end
                end
                OP_LOAD_SCATTER:
                begin
                    if (it.muon_index >= MAX_MUONS)
                        res.status = ST_RANGE;
                    else
                        scatter[it.muon_index] = it.scatter_sq;
                end
                OP_RUN_STEP: descend();
                OP_READ_DENSITY:
                begin
                    if (it.voxel_index >= NUM_VOXELS)
                        res.status = ST_RANGE;
                    else
                        res.density_value = density[it.voxel_index];
                end
                OP_INIT_DENSITY:
                    foreach (density[i]) density[i] = floor_level;
                default: ;
            endcase
            res.entries_held = HELD_W'(entry_count);
            expected_results.push_back(res);
        endfunction

        function void check_result(result_t act);
            result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, actual %h", $time, act);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (act.density_value !== exp_r.density_value)
            begin
                $display("%0t: density_value expected %h actual %h", $time,
                         exp_r.density_value, act.density_value);
                errors++;
            end
            if (act.status !== exp_r.status)
            begin
                $display("%0t: status expected %h actual %h", $time, exp_r.status, act.status);
                errors++;
            end
            if (act.entries_held !== exp_r.entries_held)
            begin
                $display("%0t: entries_held expected %0d actual %0d", $time,
                         exp_r.entries_held, act.entries_held);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    density_scoreboard sb;
    int  idle_cycles;
    bit  tx_no_gaps;
    bit  rx_no_gaps;
    bit  hold_off_request;
    int  hold_off_left;

    scatter_density_gradient_update u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // gap lengths: mostly back to back, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_no_gaps || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // monitor: every handshake at the edge goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (item_valid && item_ready)
                sb.note_item(item);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("scatter_density_gradient_update_tb failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
            result_ready  <= 1'b0;
        end
        else if (hold_off_request)
        begin
            hold_off_request <= 1'b0;
            hold_off_left    <= 400;
            result_ready     <= 1'b0;
        end
        else if (rx_no_gaps)
            result_ready <= 1'b1;
        else if ($urandom_range(0, 199) == 0)
        begin
            hold_off_left <= $urandom_range(20, 120);
            result_ready  <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) < 70);
    end

    // offer one input transaction and wait for it to be taken; valid stays up afterward
    task automatic send_item(item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    // all results back, then an idle wait before touching registers
    task automatic wait_drained();
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_regs(logic [31:0] step, logic [39:0] floor_v,
                                  logic [39:0] offset, logic [31:0] pref);
        drop_valid();
        wait_drained();
        write_reg(REG_STEP_SIZE, CFG_DATA_W'(step));
        write_reg(REG_FLOOR, floor_v);
        write_reg(REG_OFFSET, offset);
        write_reg(REG_PREFACTOR, CFG_DATA_W'(pref));
    endtask

    function automatic item_t make_item(logic [OP_W-1:0] op, int mu, int vx,
                                        logic [19:0] len, logic [31:0] sc);
        item_t it;
        it.operation   = op;
        it.muon_index  = MUON_W'(mu);
        it.voxel_index = VOX_W'(vx);
        it.path_length = len;
        it.scatter_sq  = sc;
        return it;
    endfunction

    function automatic int pick_muon();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
    endfunction

    function automatic int pick_voxel();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
    endfunction

    // small scatter values sit far below sigma at the reset offset, full-range ones far above it
    function automatic logic [31:0] pick_scatter();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 255);
            1: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // random mix without runs or inits, those are placed per phase
    function automatic item_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return make_item(OP_LOAD_ENTRY, pick_muon(), pick_voxel(),
                             20'($urandom), pick_scatter());
        else if (r < 45)
            return make_item(OP_LOAD_SCATTER, pick_muon(), $urandom, 20'($urandom),
                             pick_scatter());
        else if (r < 96)
            return make_item(OP_READ_DENSITY, $urandom, pick_voxel(), 20'($urandom),
                             $urandom);
        return make_item(OP_W'($urandom_range(5, 7)), $urandom, $urandom, 20'($urandom),
                         $urandom);
    endfunction

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        item_valid       = 1'b0;
        item             = '0;
        result_ready     = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        idle_cycles      = 0;
        tx_no_gaps       = 1'b0;
        rx_no_gaps       = 1'b0;
        hold_off_request = 1'b0;
        hold_off_left    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values first, extremes of every field
        send_item(make_item(OP_READ_DENSITY, 0, 0, 20'd0, 32'd0));
        send_item(make_item(OP_LOAD_ENTRY, 0, 0, 20'hFFFFF, 32'd0));
        send_item(make_item(OP_LOAD_ENTRY, 1023, 4095, 20'd0, 32'hFFFF_FFFF));
        send_item(make_item(OP_LOAD_ENTRY, 0, 0, 20'h00100, 32'd0));   // repeated pair
        send_item(make_item(OP_LOAD_SCATTER, 0, 4095, 20'hFFFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_LOAD_SCATTER, 1023, 0, 20'd0, 32'd0));
        send_item(make_item(OP_RUN_STEP, 0, 0, 20'd0, 32'd0));
        send_item(make_item(OP_READ_DENSITY, 0, 0, 20'd0, 32'd0));
        send_item(make_item(OP_READ_DENSITY, 1023, 4095, 20'hFFFFF, 32'hFFFF_FFFF));
        send_item(make_item(3'd5, 0, 0, 20'd0, 32'd0));
        send_item(make_item(3'd6, 1023, 4095, 20'hFFFFF, 32'hFFFF_FFFF));
        send_item(make_item(3'd7, 0, 0, 20'd0, 32'd0));

        // zero prefactor and offset give zero sigma, so the run leaves every density as it was
        write_all_regs(32'hFFFF_FFFF, 40'd0, 40'd0, 32'd0);
        send_item(make_item(OP_RUN_STEP, 0, 0, 20'd0, 32'd0));
        send_item(make_item(OP_READ_DENSITY, 0, 0, 20'd0, 32'd0));
        send_item(make_item(OP_INIT_DENSITY, 0, 0, 20'd0, 32'd0));
        send_item(make_item(OP_READ_DENSITY, 0, 4095, 20'd0, 32'd0));
        send_item(make_item(OP_LOAD_SCATTER, 0, 0, 20'd0, 32'd1));
        write_all_regs(32'hFFFF_FFFF, 40'd0, 40'd1, 32'd0);
        send_item(make_item(OP_RUN_STEP, 0, 0, 20'd0, 32'd0));
        send_item(make_item(OP_READ_DENSITY, 0, 0, 20'd0, 32'd0));

        // random phases, each with its own register setting
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_all_regs(STEP_SIZE_RST, DENSITY_FLOOR_RST, SIGMA_OFFSET_RST,
                                  ENERGY_PREFACTOR_RST);
                1: write_all_regs(32'hFFFF_FFFF, MASK40, MASK40, 32'hFFFF_FFFF);
                default: write_all_regs($urandom >> $urandom_range(0, 24),
                                        40'({$urandom, $urandom}) >> $urandom_range(0, 39),
                                        40'({$urandom, $urandom}) >> $urandom_range(0, 39),
                                        $urandom >> $urandom_range(0, 31));
            endcase
            tx_no_gaps = (phase == 2);
            rx_no_gaps = (phase == 4);
            if (phase == 3 || phase == 6)
                send_item(make_item(OP_INIT_DENSITY, 0, 0, 20'd0, 32'd0));
            if (phase == 5)
            begin
                // long receiver hold-off against a back-to-back burst
                tx_no_gaps       = 1'b1;
                hold_off_request = 1'b1;
                for (int k = 0; k < 60; k++)
                    send_item(random_item());
                tx_no_gaps = 1'b0;
            end
            for (int k = 0; k < 200; k++)
            begin
                send_item(random_item());
                if (k == 99 || k == 199)
                    send_item(make_item(OP_RUN_STEP, $urandom, $urandom, 20'($urandom),
                                        $urandom));
            end
            for (int k = 0; k < 8; k++)
                send_item(make_item(OP_READ_DENSITY, 0, $urandom_range(0, 63), 20'd0, 32'd0));
        end

        send_item(make_item(OP_READ_DENSITY, 0, $urandom, 20'd0, 32'd0));
        drop_valid();

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("scatter_density_gradient_update_tb passed");
        else
            $display("scatter_density_gradient_update_tb failed");
        $finish;
    end

endmodule

// ===== scatter_density_gradient_update.f =====
+incdir+design
design/sdgu_pkg.sv
design/scatter_density_gradient_update.sv
dv/scatter_density_gradient_update_tb.sv
